// ----- sv/cjm_pkg.sv -----
// shared types and constants for the card job machine
// no dependencies
package cjm_pkg;
	localparam int MEM_WORDS_DEF   = 100;
	localparam int BLOCK_WORDS_DEF = 10;
	localparam int PRINT_CHARS_DEF = 40;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_STEP  = 2'd2;
	localparam logic [1:0] ACT_CARD  = 2'd3;

	localparam logic [1:0] MODE_RUN  = 2'd0;
	localparam logic [1:0] MODE_HALT = 2'd1;
	localparam logic [1:0] MODE_CARD = 2'd2;
	localparam logic [1:0] MODE_ERR  = 2'd3;

	localparam logic [31:0] FILL_WORD  = 32'h2A2A2A2A;
	localparam logic [31:0] SPACE_WORD = 32'h20202020;
	localparam logic [7:0]  CH_STAR    = 8'h2A;
	localparam logic [7:0]  CH_ZERO    = 8'd48;
	localparam logic [7:0]  CH_NL      = 8'h0A;
	localparam logic [7:0]  CH_G = 8'h47;
	localparam logic [7:0]  CH_D = 8'h44;
	localparam logic [7:0]  CH_P = 8'h50;
	localparam logic [7:0]  CH_H = 8'h48;
	localparam logic [7:0]  CH_L = 8'h4C;
	localparam logic [7:0]  CH_R = 8'h52;
	localparam logic [7:0]  CH_S = 8'h53;
	localparam logic [7:0]  CH_C = 8'h43;
	localparam logic [7:0]  CH_B = 8'h42;
	localparam logic [7:0]  CH_T = 8'h54;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLR_REGS,   // reset register, flag, counter, mode
		CMD_CLR_WORD,   // write fill word at sweep address
		CMD_LOAD,       // write request word at request address
		CMD_FETCH,      // read memory at counter
		CMD_DECODE,     // latch instruction, advance counter
		CMD_READ_OP,    // read memory at operand address
		CMD_EXEC,       // apply instruction
		CMD_CARD,       // store one card word
		CMD_PRINT_RD,   // read print word
		CMD_ERR         // counter out of range
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [6:0] addr;  // sweep or print address
	} cmd_t;

	typedef enum logic [2:0] {
		INS_NOP, INS_GD, INS_PD, INS_H, INS_LR, INS_SR, INS_CR, INS_BT
	} ins_t;

	typedef struct packed {
		ins_t       ins;
		logic       bad;        // operand error
		logic [6:0] opaddr;     // operand address or block base
		logic [1:0] mode;
		logic       pc_bad;
		logic [31:0] rdata;
	} stat_t;
endpackage

// ----- sv/cjm_dp.sv -----
// datapath: memory, register, flag, counter, card bookkeeping
// depends on cjm_pkg
module cjm_dp #(
	parameter int MEM_WORDS   = cjm_pkg::MEM_WORDS_DEF,
	parameter int BLOCK_WORDS = cjm_pkg::BLOCK_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cjm_pkg::cmd_t cmd,
	input  logic [6:0]    req_addr,
	input  logic [31:0]   req_word,
	input  logic          req_last,
	output cjm_pkg::stat_t stat
);
	logic [31:0] mem [MEM_WORDS];
	logic [31:0] rdata_q;
	logic [31:0] ir_q;
	logic [31:0] greg_q;
	logic        flag_q;
	logic [6:0]  pc_q;
	logic [1:0]  mode_q;
	logic [6:0]  cptr_q;
	logic [3:0]  ctaken_q;
	logic [$clog2(MEM_WORDS)-1:0] raddr;
	logic [$clog2(MEM_WORDS)-1:0] waddr;
	logic        we;
	logic [31:0] wdata;
	logic [6:0]  rsel;
	logic [7:0]  c0, c1, c2, c3;
	logic        d2ok, d3ok;
	logic [6:0]  d2, d3;
	logic [6:0]  base, a2;
	cjm_pkg::ins_t ins;
	logic        bad;
	logic [6:0]  opaddr;

	assign c0 = ir_q[31:24];
	assign c1 = ir_q[23:16];
	assign c2 = ir_q[15:8];
	assign c3 = ir_q[7:0];
	assign d2ok = (c2 >= cjm_pkg::CH_ZERO) && (c2 <= 8'd57);
	assign d3ok = (c3 >= cjm_pkg::CH_ZERO) && (c3 <= 8'd57);
	assign d2 = 7'(c2 - cjm_pkg::CH_ZERO);
	assign d3 = 7'(c3 - cjm_pkg::CH_ZERO);
	assign base = 7'(d2 * 7'(BLOCK_WORDS));
	assign a2 = 7'(d2 * 7'd10 + d3);

	always_comb begin
		ins = cjm_pkg::INS_NOP;
		bad = 1'b0;
		opaddr = a2;
		if ((c0 == cjm_pkg::CH_G || c0 == cjm_pkg::CH_P) && c1 == cjm_pkg::CH_D) begin
			ins = (c0 == cjm_pkg::CH_G) ? cjm_pkg::INS_GD : cjm_pkg::INS_PD;
			opaddr = base;
			bad = !d2ok || (base >= 7'(MEM_WORDS));
		end else if (c0 == cjm_pkg::CH_H) begin
			ins = cjm_pkg::INS_H;
		end else if ((c0 == cjm_pkg::CH_L || c0 == cjm_pkg::CH_S || c0 == cjm_pkg::CH_C)
				&& c1 == cjm_pkg::CH_R || (c0 == cjm_pkg::CH_B && c1 == cjm_pkg::CH_T)) begin
			case (c0)
				cjm_pkg::CH_L: ins = cjm_pkg::INS_LR;
				cjm_pkg::CH_S: ins = cjm_pkg::INS_SR;
				cjm_pkg::CH_C: ins = cjm_pkg::INS_CR;
				default:       ins = cjm_pkg::INS_BT;
			endcase
			bad = !d2ok || !d3ok || (a2 >= 7'(MEM_WORDS));
		end
	end

	always_comb begin
		case (cmd.op)
			cjm_pkg::CMD_FETCH:   rsel = pc_q;
			cjm_pkg::CMD_READ_OP: rsel = opaddr;
			default:              rsel = cmd.addr;
		endcase
		raddr = rsel[$clog2(MEM_WORDS)-1:0];
		we = 1'b0;
		waddr = cmd.addr[$clog2(MEM_WORDS)-1:0];
		wdata = cjm_pkg::FILL_WORD;
		case (cmd.op)
			cjm_pkg::CMD_CLR_WORD: we = 1'b1;
			cjm_pkg::CMD_LOAD: begin
				we = req_addr < 7'(MEM_WORDS);
				waddr = req_addr[$clog2(MEM_WORDS)-1:0];
				wdata = req_word;
			end
			cjm_pkg::CMD_CARD: begin
				we = (mode_q == cjm_pkg::MODE_CARD) && (cptr_q < 7'(MEM_WORDS));
				waddr = cptr_q[$clog2(MEM_WORDS)-1:0];
				wdata = req_word;
			end
			cjm_pkg::CMD_EXEC: begin
				we = !bad && ins == cjm_pkg::INS_SR;
				waddr = opaddr[$clog2(MEM_WORDS)-1:0];
				wdata = greg_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
		if (cmd.op == cjm_pkg::CMD_DECODE)
			ir_q <= rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			greg_q <= cjm_pkg::SPACE_WORD;
			flag_q <= 1'b0;
			pc_q <= '0;
			mode_q <= cjm_pkg::MODE_RUN;
			cptr_q <= '0;
			ctaken_q <= '0;
		end else begin
			case (cmd.op)
				cjm_pkg::CMD_CLR_REGS: begin
					greg_q <= cjm_pkg::SPACE_WORD;
					flag_q <= 1'b0;
					pc_q <= '0;
					mode_q <= cjm_pkg::MODE_RUN;
					cptr_q <= '0;
					ctaken_q <= '0;
				end
				cjm_pkg::CMD_ERR: mode_q <= cjm_pkg::MODE_ERR;
				cjm_pkg::CMD_DECODE: pc_q <= 7'(pc_q + 7'd1);
				cjm_pkg::CMD_EXEC: begin
					if (bad)
						mode_q <= cjm_pkg::MODE_ERR;
					else case (ins)
						cjm_pkg::INS_GD: begin
							cptr_q <= opaddr;
							ctaken_q <= '0;
							mode_q <= cjm_pkg::MODE_CARD;
						end
						cjm_pkg::INS_H:  mode_q <= cjm_pkg::MODE_HALT;
						cjm_pkg::INS_LR: greg_q <= rdata_q;
						cjm_pkg::INS_CR: flag_q <= (greg_q == rdata_q);
						cjm_pkg::INS_BT: if (flag_q) pc_q <= opaddr;
						default: ;
					endcase
				end
				cjm_pkg::CMD_CARD: begin
					if (mode_q == cjm_pkg::MODE_CARD) begin
						cptr_q <= 7'(cptr_q + 7'd1);
						ctaken_q <= 4'(ctaken_q + 4'd1);
						if (req_last || 4'(ctaken_q + 4'd1) >= 4'(BLOCK_WORDS))
							mode_q <= cjm_pkg::MODE_RUN;
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.ins = ins;
	assign stat.bad = bad;
	assign stat.opaddr = opaddr;
	assign stat.mode = mode_q;
	assign stat.pc_bad = pc_q >= 7'(MEM_WORDS);
	assign stat.rdata = rdata_q;
endmodule

// ----- sv/cjm_ctrl.sv -----
// controller: sequences clear, load, step, card and print
// depends on cjm_pkg
module cjm_ctrl #(
	parameter int MEM_WORDS   = cjm_pkg::MEM_WORDS_DEF,
	parameter int BLOCK_WORDS = cjm_pkg::BLOCK_WORDS_DEF,
	parameter int PRINT_CHARS = cjm_pkg::PRINT_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic [1:0]     in_action,
	output logic           in_ready,
	output cjm_pkg::cmd_t  cmd,
	input  cjm_pkg::stat_t stat,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_kind,
	output logic [7:0]     out_char,
	output logic           out_last
);
	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CLR, S_FETCH, S_DECODE, S_READ, S_EXEC,
		S_PRD, S_PWAIT, S_PCHAR, S_NL, S_EMIT, S_STATUS
	} state_t;

	state_t      state_q;
	logic [6:0]  addr_q;      // sweep or print word address
	logic [3:0]  words_q;     // print words done
	logic [1:0]  pos_q;
	logic [5:0]  nchar_q;
	logic        nl2_q;
	logic [31:0] pword_q;
	logic [7:0]  ch;

	assign in_ready = (state_q == S_IDLE);
	assign ch = pword_q[31 - 8*pos_q -: 8];

	always_comb begin
		cmd.op = cjm_pkg::CMD_NONE;
		cmd.addr = addr_q;
		if (state_q == S_IDLE && in_fire) begin
			case (in_action)
				cjm_pkg::ACT_CLEAR: cmd.op = cjm_pkg::CMD_CLR_REGS;
				cjm_pkg::ACT_LOAD:  cmd.op = cjm_pkg::CMD_LOAD;
				cjm_pkg::ACT_CARD:  cmd.op = cjm_pkg::CMD_CARD;
				default: begin
					if (stat.mode == cjm_pkg::MODE_RUN)
						cmd.op = stat.pc_bad ? cjm_pkg::CMD_ERR : cjm_pkg::CMD_FETCH;
				end
			endcase
		end else begin
			case (state_q)
				S_INIT,
				S_CLR:    cmd.op = cjm_pkg::CMD_CLR_WORD;
				S_FETCH:  cmd.op = cjm_pkg::CMD_FETCH;
				S_DECODE: cmd.op = cjm_pkg::CMD_DECODE;
				S_READ:   cmd.op = cjm_pkg::CMD_READ_OP;
				S_EXEC:   cmd.op = cjm_pkg::CMD_EXEC;
				S_PRD:    cmd.op = cjm_pkg::CMD_PRINT_RD;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			addr_q <= '0;
			words_q <= '0;
			pos_q <= '0;
			nchar_q <= '0;
			nl2_q <= 1'b0;
			pword_q <= '0;
			out_valid <= 1'b0;
			out_kind <= 1'b0;
			out_char <= '0;
			out_last <= 1'b0;
		end else begin
			case (state_q)
				// fill memory after reset, no status item
				S_INIT: begin
					addr_q <= 7'(addr_q + 7'd1);
					if (addr_q == 7'(MEM_WORDS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: if (in_fire) begin
					addr_q <= '0;
					if (in_action == cjm_pkg::ACT_CLEAR)
						state_q <= S_CLR;
					else if (in_action == cjm_pkg::ACT_STEP &&
							stat.mode == cjm_pkg::MODE_RUN && !stat.pc_bad)
						state_q <= S_FETCH;
					else
						state_q <= S_STATUS;
				end
				S_CLR: begin
					addr_q <= 7'(addr_q + 7'd1);
					if (addr_q == 7'(MEM_WORDS - 1))
						state_q <= S_STATUS;
				end
				S_FETCH:  state_q <= S_DECODE;
				S_DECODE: state_q <= S_READ;
				S_READ:   state_q <= S_EXEC;
				S_EXEC: begin
					addr_q <= stat.opaddr;
					words_q <= '0;
					pos_q <= '0;
					nchar_q <= '0;
					nl2_q <= 1'b0;
					if (!stat.bad && stat.ins == cjm_pkg::INS_PD)
						state_q <= S_PRD;
					else if (stat.ins == cjm_pkg::INS_H)
						state_q <= S_NL;
					else
						state_q <= S_STATUS;
				end
				S_PRD: begin
					if (words_q == 4'(BLOCK_WORDS) || addr_q >= 7'(MEM_WORDS))
						state_q <= S_STATUS;
					else
						state_q <= S_PWAIT;
				end
				S_PWAIT: begin
					pword_q <= stat.rdata;
					state_q <= S_PCHAR;
				end
				S_PCHAR: begin
					if (ch == cjm_pkg::CH_STAR || nchar_q == 6'(PRINT_CHARS)) begin
						state_q <= S_STATUS;
					end else begin
						out_valid <= 1'b1;
						out_kind <= 1'b1;
						out_char <= ch;
						out_last <= 1'b0;
						nchar_q <= 6'(nchar_q + 6'd1);
						state_q <= S_EMIT;
					end
				end
				S_NL: begin
					out_valid <= 1'b1;
					out_kind <= 1'b1;
					out_char <= cjm_pkg::CH_NL;
					out_last <= 1'b0;
					state_q <= S_EMIT;
				end
				S_EMIT: if (out_ready) begin
					out_valid <= 1'b0;
					if (out_last) begin
						state_q <= S_IDLE;
					end else if (out_kind && out_char == cjm_pkg::CH_NL && !nl2_q &&
							words_q == 4'd0 && nchar_q == 6'd0) begin
						nl2_q <= 1'b1;
						state_q <= S_NL;
					end else if (nl2_q) begin
						state_q <= S_STATUS;
					end else if (pos_q == 2'd3) begin
						pos_q <= '0;
						words_q <= 4'(words_q + 4'd1);
						addr_q <= 7'(addr_q + 7'd1);
						state_q <= S_PRD;
					end else begin
						pos_q <= 2'(pos_q + 2'd1);
						state_q <= S_PCHAR;
					end
				end
				S_STATUS: begin
					out_valid <= 1'b1;
					out_kind <= 1'b0;
					out_char <= '0;
					out_last <= 1'b1;
					state_q <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/card_job_machine_step.sv -----
// card job machine top level: controller plus datapath
// depends on cjm_pkg, cjm_ctrl, cjm_dp
// each request ends in one status item; load, card word and idle steps go straight to it,
// a simple instruction steps through fetch, decode, operand read and execute, clear sweeps
// all MEM_WORDS words, and halt emits two newlines; print reads each word of the block and
// emits its characters until '*', PRINT_CHARS characters or the end of the block
// one request at a time: the next can be taken in the cycle after the status item is taken
// arst_n clears control state, then the controller fills every memory word with '*'
module card_job_machine_step #(
	parameter int MEM_WORDS   = cjm_pkg::MEM_WORDS_DEF,
	parameter int BLOCK_WORDS = cjm_pkg::BLOCK_WORDS_DEF,
	parameter int PRINT_CHARS = cjm_pkg::PRINT_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // action[1:0], address[8:2], word[40:9], zero pad
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_char[7:0], status[9:8], zero pad
	output logic        m_tuser,   // kind
	output logic        m_tlast    // is_last
);
	cjm_pkg::cmd_t  cmd;
	cjm_pkg::stat_t stat;
	logic           kind;
	logic [7:0]     ch;
	logic           fire;

	assign fire = s_tvalid && s_tready;

	cjm_ctrl #(.MEM_WORDS(MEM_WORDS), .BLOCK_WORDS(BLOCK_WORDS),
			.PRINT_CHARS(PRINT_CHARS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(fire), .in_action(s_tdata[1:0]),
		.in_ready(s_tready), .cmd(cmd), .stat(stat),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_kind(kind), .out_char(ch), .out_last(m_tlast)
	);

	cjm_dp #(.MEM_WORDS(MEM_WORDS), .BLOCK_WORDS(BLOCK_WORDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.req_addr(s_tdata[8:2]), .req_word(s_tdata[40:9]),
		.req_last(s_tlast), .stat(stat)
	);

	// status follows the live run mode, which is settled while an item waits
	assign m_tuser = kind;
	assign m_tdata = {6'd0, stat.mode, ch};
endmodule

// ----- verif/tb_card_job_machine_step.sv -----
// self-checking testbench for card_job_machine_step: scoreboard class predicts each request
// depends on cjm_pkg and the card_job_machine_step rtl
`timescale 1ns / 1ps

module tb_card_job_machine_step;

	typedef struct {
		logic       kind;
		logic [7:0] ch;
		logic [1:0] st;
		logic       lst;
	} out_item_t;

	// machine shadow plus queue of expected output items
	class machine_board;
		logic [31:0] mem [cjm_pkg::MEM_WORDS_DEF];
		logic [31:0] gen_reg;
		logic        flag;
		logic [6:0]  pc;
		logic [1:0]  mode;
		logic [6:0]  card_ptr;
		logic [3:0]  card_cnt;
		out_item_t   pending_out [$];
		int          errors;

		function void clear_state();
			foreach (mem[i]) mem[i] = cjm_pkg::FILL_WORD;
			gen_reg  = cjm_pkg::SPACE_WORD;
			flag     = 1'b0;
			pc       = '0;
			mode     = cjm_pkg::MODE_RUN;
			card_ptr = '0;
			card_cnt = '0;
		endfunction

		function logic [7:0] char_at(logic [31:0] w, int p);
			return w[31 - 8 * p -: 8];
		endfunction

		function bit is_dig(logic [7:0] c);
			return c >= cjm_pkg::CH_ZERO && c <= cjm_pkg::CH_ZERO + 8'd9;
		endfunction

		// one instruction, printed characters go to prt
		function void run_instr(ref logic [7:0] prt [$]);
			logic [31:0] ir;
			logic [7:0]  c0, c1, c2, c3;
			int          base, addr;
			bit          stop;
			if (pc >= cjm_pkg::MEM_WORDS_DEF) begin
				mode = cjm_pkg::MODE_ERR;
				return;
			end
			ir = mem[pc];
			pc = pc + 7'd1;
			c0 = char_at(ir, 0);
			c1 = char_at(ir, 1);
			c2 = char_at(ir, 2);
			c3 = char_at(ir, 3);
			if ((c0 == cjm_pkg::CH_G || c0 == cjm_pkg::CH_P) && c1 == cjm_pkg::CH_D) begin
				if (!is_dig(c2)) begin
					mode = cjm_pkg::MODE_ERR;
					return;
				end
				base = (c2 - cjm_pkg::CH_ZERO) * cjm_pkg::BLOCK_WORDS_DEF;
				if (base >= cjm_pkg::MEM_WORDS_DEF) begin
					mode = cjm_pkg::MODE_ERR;
					return;
				end
				if (c0 == cjm_pkg::CH_G) begin
					card_ptr = 7'(base);
					card_cnt = '0;
					mode     = cjm_pkg::MODE_CARD;
				end else begin
					stop = 0;
					for (int w = 0; w < cjm_pkg::BLOCK_WORDS_DEF && !stop; w++) begin
						if (base + w >= cjm_pkg::MEM_WORDS_DEF) break;
						for (int p = 0; p < 4; p++) begin
							if (char_at(mem[base + w], p) == cjm_pkg::CH_STAR
									|| prt.size() >= cjm_pkg::PRINT_CHARS_DEF) begin
								stop = 1;
								break;
							end
							prt.push_back(char_at(mem[base + w], p));
						end
					end
				end
				return;
			end
			if (c0 == cjm_pkg::CH_H) begin
				prt.push_back(cjm_pkg::CH_NL);
				prt.push_back(cjm_pkg::CH_NL);
				mode = cjm_pkg::MODE_HALT;
				return;
			end
			if (!((c0 == cjm_pkg::CH_L || c0 == cjm_pkg::CH_S || c0 == cjm_pkg::CH_C)
					&& c1 == cjm_pkg::CH_R)
					&& !(c0 == cjm_pkg::CH_B && c1 == cjm_pkg::CH_T))
				return;
			if (!is_dig(c2) || !is_dig(c3)) begin
				mode = cjm_pkg::MODE_ERR;
				return;
			end
			addr = (c2 - cjm_pkg::CH_ZERO) * 10 + (c3 - cjm_pkg::CH_ZERO);
			if (addr >= cjm_pkg::MEM_WORDS_DEF) begin
				mode = cjm_pkg::MODE_ERR;
				return;
			end
			case (c0)
				cjm_pkg::CH_L: gen_reg = mem[addr];
				cjm_pkg::CH_S: mem[addr] = gen_reg;
				cjm_pkg::CH_C: flag = (gen_reg == mem[addr]);
				default: if (flag) pc = 7'(addr);
			endcase
		endfunction

		function void note_request(logic [1:0] act, logic [6:0] adr, logic [31:0] wd,
				logic lst);
			logic [7:0] prt [$];
			out_item_t  it;
			case (act)
				cjm_pkg::ACT_CLEAR: clear_state();
				cjm_pkg::ACT_LOAD: if (adr < cjm_pkg::MEM_WORDS_DEF) mem[adr] = wd;
				cjm_pkg::ACT_STEP: if (mode == cjm_pkg::MODE_RUN) run_instr(prt);
				default: if (mode == cjm_pkg::MODE_CARD) begin
					if (card_ptr < cjm_pkg::MEM_WORDS_DEF) mem[card_ptr] = wd;
					card_ptr = card_ptr + 7'd1;
					card_cnt = card_cnt + 4'd1;
					if (lst || card_cnt >= cjm_pkg::BLOCK_WORDS_DEF) mode = cjm_pkg::MODE_RUN;
				end
			endcase
			// every item of a request carries the mode after it
			foreach (prt[i]) begin
				it = '{1'b1, prt[i], mode, 1'b0};
				pending_out.push_back(it);
			end
			it = '{1'b0, 8'h00, mode, 1'b1};
			pending_out.push_back(it);
		endfunction

		function void check_result(logic kind, logic [7:0] ch, logic [1:0] st, logic lst);
			out_item_t e;
			if (pending_out.size() == 0) begin
				$error("unexpected output item kind=%0d char=%h", kind, ch);
				errors++;
				return;
			end
			e = pending_out.pop_front();
			if (kind !== e.kind) begin
				$error("kind: expected %0d actual %0d", e.kind, kind);
				errors++;
			end
			if (ch !== e.ch) begin
				$error("out_char: expected %h actual %h", e.ch, ch);
				errors++;
			end
			if (st !== e.st) begin
				$error("status: expected %0d actual %0d", e.st, st);
				errors++;
			end
			if (lst !== e.lst) begin
				$error("is_last: expected %0d actual %0d", e.lst, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	machine_board board;
	int          results_seen;
	int          ready_gap;
	int          ready_hold;
	bit          hold_done;
	int          requests_sent;

	always #6 clk = ~clk;

	card_job_machine_step u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// output side: check accepted items, then pick the next ready value
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			board.check_result(m_tuser, m_tdata[7:0], m_tdata[9:8], m_tlast);
			results_seen++;
		end
		// one long hold-off once the machine is busy, sender keeps offering
		if (!hold_done && results_seen >= 150) begin
			hold_done = 1;
			ready_hold = 400;
		end
		if (ready_hold > 0) begin
			ready_hold--;
			m_tready <= 1'b0;
		end else if (ready_gap > 0) begin
			ready_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			// stretches with no stalls between bursts of short and rare long gaps
			if ((results_seen / 64) % 2 == 1 && $urandom_range(0, 3) == 0)
				ready_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
					: $urandom_range(1, 3);
		end
	end

	// drive one request and wait for it to be accepted
	task automatic send_req(logic [1:0] act, logic [6:0] adr, logic [31:0] wd, logic lst);
		logic [47:0] packed_req;
		int          gap;
		packed_req = {7'd0, wd, adr, act};
		s_tvalid <= 1'b1;
		s_tdata  <= packed_req;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		board.note_request(act, adr, wd, lst);
		requests_sent++;
		gap = 0;
		if ((requests_sent / 50) % 2 == 1 && $urandom_range(0, 2) == 0)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] ins_word(logic [7:0] a, logic [7:0] b, int d2, int d3);
		return {a, b, cjm_pkg::CH_ZERO + 8'(d2), cjm_pkg::CH_ZERO + 8'(d3)};
	endfunction

	// random instruction, mostly well-formed operands
	function automatic logic [31:0] rand_ins();
		logic [31:0] w;
		case ($urandom_range(0, 7))
			0: w = ins_word(cjm_pkg::CH_G, cjm_pkg::CH_D, $urandom_range(1, 9),
				$urandom_range(0, 9));
			1: w = ins_word(cjm_pkg::CH_P, cjm_pkg::CH_D, $urandom_range(1, 9),
				$urandom_range(0, 9));
			2: w = {cjm_pkg::CH_H, 8'($urandom), 8'($urandom), 8'($urandom)};
			3: w = ins_word(cjm_pkg::CH_L, cjm_pkg::CH_R, $urandom_range(0, 9),
				$urandom_range(0, 9));
			4: w = ins_word(cjm_pkg::CH_S, cjm_pkg::CH_R, $urandom_range(1, 9),
				$urandom_range(0, 9));
			5: w = ins_word(cjm_pkg::CH_C, cjm_pkg::CH_R, $urandom_range(0, 9),
				$urandom_range(0, 9));
			6: w = ins_word(cjm_pkg::CH_B, cjm_pkg::CH_T, 0, $urandom_range(0, 9));
			default: w = $urandom;
		endcase
		if ($urandom_range(0, 14) == 0) w[15:8] = 8'($urandom);
		if ($urandom_range(0, 14) == 0) w[7:0] = 8'($urandom);
		return w;
	endfunction

	// printable text with an occasional end marker
	function automatic logic [31:0] rand_text();
		logic [31:0] w;
		for (int p = 0; p < 4; p++) w[31 - 8 * p -: 8] = 8'($urandom_range(8'h20, 8'h7E));
		if ($urandom_range(0, 7) == 0) w[$urandom_range(0, 3) * 8 +: 8] = cjm_pkg::CH_STAR;
		if ($urandom_range(0, 9) == 0) w = $urandom;
		return w;
	endfunction

	task automatic feed_cards();
		while (board.mode == cjm_pkg::MODE_CARD)
			send_req(cjm_pkg::ACT_CARD, 7'($urandom), rand_text(), $urandom_range(0, 4) == 0);
	endtask

	initial begin
		board = new();
		board.clear_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state first, then a clear
		send_req(cjm_pkg::ACT_STEP, '0, '0, 1'b0);                 // fill word runs as a no-op
		send_req(cjm_pkg::ACT_CLEAR, '0, '0, 1'b0);
		send_req(cjm_pkg::ACT_CARD, 7'd5, 32'h41424344, 1'b1);     // card with no read pending
		send_req(cjm_pkg::ACT_LOAD, 7'd0, ins_word(cjm_pkg::CH_G, cjm_pkg::CH_D, 1, 0), 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd1, ins_word(cjm_pkg::CH_P, cjm_pkg::CH_D, 1, 0), 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd2, ins_word(cjm_pkg::CH_L, cjm_pkg::CH_R, 1, 0), 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd3, ins_word(cjm_pkg::CH_S, cjm_pkg::CH_R, 2, 5), 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd4, ins_word(cjm_pkg::CH_C, cjm_pkg::CH_R, 2, 5), 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd5, ins_word(cjm_pkg::CH_B, cjm_pkg::CH_T, 0, 7), 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd7, ins_word(cjm_pkg::CH_C, cjm_pkg::CH_R, 3, 0), 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd8, 32'h51515151, 1'b0);     // unknown opcode
		send_req(cjm_pkg::ACT_LOAD, 7'd9, ins_word(cjm_pkg::CH_P, cjm_pkg::CH_D, 2, 0), 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd127, 32'hFFFFFFFF, 1'b0);   // address out of range
		send_req(cjm_pkg::ACT_STEP, '0, '0, 1'b0);                 // GD into block 1
		for (int i = 0; i < 10; i++)
			send_req(cjm_pkg::ACT_CARD, '0, 32'h41414141 + i, 1'b0);  // full block, no last
		for (int i = 0; i < 9; i++) send_req(cjm_pkg::ACT_STEP, '0, '0, 1'b0);  // PD 40 chars
		send_req(cjm_pkg::ACT_LOAD, 7'd10, {cjm_pkg::CH_H, 8'hFF, 8'h00, 8'hFF}, 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd9, {cjm_pkg::CH_H, 8'h00, 8'h00, 8'h00}, 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd11, ins_word(cjm_pkg::CH_B, cjm_pkg::CH_T, 9, 9), 1'b0);
		send_req(cjm_pkg::ACT_STEP, '0, '0, 1'b0);
		send_req(cjm_pkg::ACT_STEP, '0, '0, 1'b0);                 // card word at 12 runs as a no-op
		// counter running off the end of memory, then bad operand digit
		send_req(cjm_pkg::ACT_CLEAR, '0, '0, 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd0, ins_word(cjm_pkg::CH_B, cjm_pkg::CH_T, 9, 9), 1'b0);
		send_req(cjm_pkg::ACT_STEP, '0, '0, 1'b0);                 // flag clear: no jump
		send_req(cjm_pkg::ACT_LOAD, 7'd99, 32'h20202020, 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd1, ins_word(cjm_pkg::CH_C, cjm_pkg::CH_R, 9, 9), 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd2, ins_word(cjm_pkg::CH_B, cjm_pkg::CH_T, 9, 9), 1'b0);
		for (int i = 0; i < 5; i++) send_req(cjm_pkg::ACT_STEP, '0, '0, 1'b0);
		send_req(cjm_pkg::ACT_CLEAR, '0, '0, 1'b0);
		send_req(cjm_pkg::ACT_LOAD, 7'd0, {cjm_pkg::CH_L, cjm_pkg::CH_R, 8'h3A,
			cjm_pkg::CH_ZERO}, 1'b0);
		send_req(cjm_pkg::ACT_STEP, '0, '0, 1'b0);

		// random programs: load, step through, feed cards when a read waits
		while (requests_sent < 260) begin
			send_req(cjm_pkg::ACT_CLEAR, '0, '0, 1'b0);
			for (int i = 0; i < $urandom_range(6, 10); i++)
				send_req(cjm_pkg::ACT_LOAD, 7'(i), rand_ins(), 1'b0);
			for (int i = 0; i < $urandom_range(0, 3); i++)
				send_req(cjm_pkg::ACT_LOAD, ($urandom_range(0, 5) == 0) ? 7'($urandom)
					: 7'($urandom_range(10, 99)), rand_text(), 1'b0);
			for (int i = 0; i < $urandom_range(6, 14); i++) begin
				if ($urandom_range(0, 19) == 0)
					send_req(cjm_pkg::ACT_CARD, 7'($urandom), $urandom,
						1'($urandom_range(0, 1)));
				send_req(cjm_pkg::ACT_STEP, 7'($urandom), $urandom, 1'($urandom_range(0, 1)));
				feed_cards();
			end
		end
		s_tvalid <= 1'b0;

		while (board.pending_out.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.pending_out.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#30ms;
		$display("FAIL");
		$finish;
	end
endmodule
